/* design/irac_pkg.sv */
`timescale 1ns / 1ps

package irac_pkg;

    // Fixed geometry of one section.
    localparam int unsigned DATA_BITS = 56;
    localparam int unsigned DUR_W     = 16;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned BIT_IDX_W = 6;
    localparam int unsigned CFG_IDX_W = 4;

    // Symbol positions inside one section run.
    localparam logic [STEP_W-1:0] STEP_FRAME_HDR   = 6'd0;
    localparam logic [STEP_W-1:0] STEP_SECTION_HDR = 6'd1;
    localparam logic [STEP_W-1:0] STEP_DATA_FIRST  = 6'd2;
    localparam logic [STEP_W-1:0] STEP_FOOT        = 6'd58;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SPACE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_MARK  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_SPACE = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_GAP   = 4'd7;

    // Reset values of the timing registers, in microseconds.
    localparam logic [DUR_W-1:0] RST_HEADER_MARK   = 16'd690;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE  = 16'd17844;
    localparam logic [DUR_W-1:0] RST_SECTION_MARK  = 16'd3086;
    localparam logic [DUR_W-1:0] RST_SECTION_SPACE = 16'd8864;
    localparam logic [DUR_W-1:0] RST_BIT_MARK      = 16'd586;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE     = 16'd1432;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE    = 16'd436;
    localparam logic [DUR_W-1:0] RST_SECTION_GAP   = 16'd2886;

    typedef struct packed {
        logic [DATA_BITS-1:0] section_bits;
        logic                 last_section;
    } in_t;

    typedef struct packed {
        logic [DUR_W-1:0] mark_us;
        logic [DUR_W-1:0] space_us;
        logic             end_of_run;
        logic             end_of_frame;
        logic             error_code;
    } out_t;

    // Classified section handed from the front to the back.
    typedef struct packed {
        logic [DATA_BITS-1:0] section_bits;
        logic                 last_section;
        logic                 with_header;
        logic                 error;
    } cmd_t;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [DUR_W-1:0] section_mark;
        logic [DUR_W-1:0] section_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] section_gap;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/irac_front.sv */
`timescale 1ns / 1ps

module irac_front #(
    parameter int unsigned MAX_SECTIONS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  irac_pkg::in_t     in_item,
    input  logic              q_full,
    output logic              push,
    output irac_pkg::cmd_t    push_cmd
);

    localparam logic [irac_pkg::COUNT_W-1:0] MAX_CNT = irac_pkg::COUNT_W'(MAX_SECTIONS);

    logic [irac_pkg::COUNT_W-1:0] sent_reg;
    logic [irac_pkg::COUNT_W-1:0] sent_next;
    logic                         over_limit;

    // An item is taken whenever the queue has room.
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // Classify the section against the count of sections already in this frame.
    always_comb
    begin
        over_limit            = (sent_reg >= MAX_CNT);
        push_cmd.section_bits = in_item.section_bits;
        push_cmd.last_section = in_item.last_section;
        push_cmd.error        = over_limit;
        push_cmd.with_header  = !over_limit && (sent_reg == '0);
        sent_next             = sent_reg;
        if (in_item.last_section)
        begin
            sent_next = '0;
        end
        else if (!over_limit)
        begin
            sent_next = sent_reg + 1'b1;
        end
    end

    // Section count of the current frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg <= '0;
        end
        else if (push)
        begin
            sent_reg <= sent_next;
        end
    end

endmodule

/* design/irac_queue.sv */
`timescale 1ns / 1ps

module irac_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  irac_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output irac_pkg::cmd_t        head,
    output irac_pkg::q_status_t   status
);

    irac_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head         = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/irac_back.sv */
`timescale 1ns / 1ps

module irac_back #(
    parameter int unsigned FINAL_GAP_US = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  irac_pkg::cfg_t      cfg,
    input  irac_pkg::cmd_t      head,
    input  logic                q_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output irac_pkg::out_t      out_item
);

    localparam logic [irac_pkg::DUR_W-1:0] LAST_FOOT_SPACE = irac_pkg::DUR_W'(FINAL_GAP_US);

    logic                            busy_reg;
    logic                            busy_next;
    irac_pkg::cmd_t                  cmd_reg;
    logic [irac_pkg::STEP_W-1:0]     step_reg;
    logic                            out_valid_reg;
    irac_pkg::out_t                  out_reg;

    irac_pkg::cmd_t                  cur_cmd;
    logic [irac_pkg::STEP_W-1:0]     cur_step;
    logic [irac_pkg::BIT_IDX_W-1:0]  bit_idx;
    logic                            have_sym;
    logic                            advance;
    logic                            is_last;
    irac_pkg::out_t                  sym;

    // The output register accepts a new symbol when empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign have_sym  = busy_reg || q_valid;
    assign pop       = advance && !busy_reg && q_valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Pick the section being worked on; a fresh one starts straight from the queue head.
    always_comb
    begin
        cur_cmd  = busy_reg ? cmd_reg : head;
        cur_step = step_reg;
        if (!busy_reg)
        begin
            cur_step = head.with_header ? irac_pkg::STEP_FRAME_HDR
                                        : irac_pkg::STEP_SECTION_HDR;
        end
        bit_idx = cur_step - irac_pkg::STEP_DATA_FIRST;
    end

    // Build the symbol for the current step.
    always_comb
    begin
        sym.mark_us      = cfg.bit_mark;
        sym.space_us     = cfg.zero_space;
        sym.end_of_run   = 1'b0;
        sym.end_of_frame = 1'b0;
        sym.error_code   = 1'b0;
        is_last          = 1'b0;
        if (cur_cmd.error)
        begin
            sym.mark_us      = '0;
            sym.space_us     = '0;
            sym.end_of_run   = 1'b1;
            sym.end_of_frame = cur_cmd.last_section;
            sym.error_code   = 1'b1;
            is_last          = 1'b1;
        end
        else if (cur_step == irac_pkg::STEP_FRAME_HDR)
        begin
            sym.mark_us  = cfg.header_mark;
            sym.space_us = cfg.header_space;
        end
        else if (cur_step == irac_pkg::STEP_SECTION_HDR)
        begin
            sym.mark_us  = cfg.section_mark;
            sym.space_us = cfg.section_space;
        end
        else if (cur_step == irac_pkg::STEP_FOOT)
        begin
            sym.space_us     = cur_cmd.last_section ? LAST_FOOT_SPACE : cfg.section_gap;
            sym.end_of_run   = 1'b1;
            sym.end_of_frame = cur_cmd.last_section;
            is_last          = 1'b1;
        end
        else if (cur_cmd.section_bits[bit_idx])
        begin
            sym.space_us = cfg.one_space;
        end
        busy_next = busy_reg;
        if (advance && have_sym)
        begin
            busy_next = !is_last;
        end
    end

    // Sequencer control and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= have_sym;
        end
    end

    // Sequencer payload and output symbol.
    always_ff @(posedge clk)
    begin
        if (advance && have_sym)
        begin
            out_reg  <= sym;
            cmd_reg  <= cur_cmd;
            step_reg <= cur_step + 1'b1;
        end
    end

endmodule

/* design/ir_ac_frame_symbol_encoder_core.sv */
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// in        in_valid/in_stall    in_item  (section_bits, last_section)
// out       out_valid/out_stall  out_item (mark_us, space_us, end_of_run,
//                                          end_of_frame, error_code)
// cfg       cfg_we               cfg_index, cfg_data
//
// One symbol leaves per cycle unless out_stall holds it; a section opening a frame
// gives 59 symbols, any other 58, one over the limit a single error symbol.
// The back sequencer, one symbol per cycle unless stalled, sets it; a two-entry
// queue lets the front take the next section while the back still works.
// Reset loads the default timings, starts a new frame and empties the queue.
// out_stall holds the output register; in_stall rises only while the queue is full.

module ir_ac_frame_symbol_encoder_core #(
    parameter int unsigned MAX_SECTIONS = 3,
    parameter int unsigned FINAL_GAP_US = 65535
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  irac_pkg::in_t                      in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output irac_pkg::out_t                     out_item,
    input  logic                               cfg_we,
    input  logic [irac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irac_pkg::DUR_W-1:0]         cfg_data
);

    irac_pkg::cfg_t      cfg_reg;
    irac_pkg::cmd_t      push_cmd;
    irac_pkg::cmd_t      head;
    irac_pkg::q_status_t q_status;
    logic                push;
    logic                pop;

    // Timing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark   <= irac_pkg::RST_HEADER_MARK;
            cfg_reg.header_space  <= irac_pkg::RST_HEADER_SPACE;
            cfg_reg.section_mark  <= irac_pkg::RST_SECTION_MARK;
            cfg_reg.section_space <= irac_pkg::RST_SECTION_SPACE;
            cfg_reg.bit_mark      <= irac_pkg::RST_BIT_MARK;
            cfg_reg.one_space     <= irac_pkg::RST_ONE_SPACE;
            cfg_reg.zero_space    <= irac_pkg::RST_ZERO_SPACE;
            cfg_reg.section_gap   <= irac_pkg::RST_SECTION_GAP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                irac_pkg::REG_HEADER_MARK:   cfg_reg.header_mark   <= cfg_data;
                irac_pkg::REG_HEADER_SPACE:  cfg_reg.header_space  <= cfg_data;
                irac_pkg::REG_SECTION_MARK:  cfg_reg.section_mark  <= cfg_data;
                irac_pkg::REG_SECTION_SPACE: cfg_reg.section_space <= cfg_data;
                irac_pkg::REG_BIT_MARK:      cfg_reg.bit_mark      <= cfg_data;
                irac_pkg::REG_ONE_SPACE:     cfg_reg.one_space     <= cfg_data;
                irac_pkg::REG_ZERO_SPACE:    cfg_reg.zero_space    <= cfg_data;
                irac_pkg::REG_SECTION_GAP:   cfg_reg.section_gap   <= cfg_data;
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Front: accepts sections and tracks the frame.
    irac_front #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_full   (q_status.full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue between front and back.
    irac_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Back: emits the symbol run of each section.
    irac_back #(
        .FINAL_GAP_US (FINAL_GAP_US)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_valid   (!q_status.empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    // An error symbol carries zero durations and closes its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.error_code |->
            out_item.mark_us == '0 && out_item.space_us == '0 && out_item.end_of_run)
    else $error("error symbol with nonzero durations or open run");

    // A frame can only close on the last symbol of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.end_of_frame |-> out_item.end_of_run)
    else $error("end of frame without end of run");

    // The queue never pops while empty nor accepts while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && q_status.empty) && !(push && q_status.full))
    else $error("queue overrun or underrun");

endmodule

/* test/tb_ir_ac_frame_symbol_encoder_core.sv */
`timescale 1ns / 1ps

module tb_ir_ac_frame_symbol_encoder_core;

    localparam int unsigned MAX_SECTIONS  = 3;
    localparam int unsigned FINAL_GAP_US  = 65535;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    typedef enum int {TIMING_ZERO, TIMING_FULL, TIMING_RANDOM} timing_mode_t;

    // Keeps the expected symbol stream of the encoder and checks the real one.
    class symbol_scoreboard_t;
        irac_pkg::out_t             expected_symbols[$];
        irac_pkg::cfg_t             timing;
        int unsigned                sections_in_frame;
        int unsigned                max_sections;
        logic [irac_pkg::DUR_W-1:0] last_foot_space;
        int unsigned                mismatches;

        function new(int unsigned max_sec, int unsigned gap);
            max_sections          = max_sec;
            last_foot_space       = irac_pkg::DUR_W'(gap);
            mismatches            = 0;
            timing.header_mark    = irac_pkg::RST_HEADER_MARK;
            timing.header_space   = irac_pkg::RST_HEADER_SPACE;
            timing.section_mark   = irac_pkg::RST_SECTION_MARK;
            timing.section_space  = irac_pkg::RST_SECTION_SPACE;
            timing.bit_mark       = irac_pkg::RST_BIT_MARK;
            timing.one_space      = irac_pkg::RST_ONE_SPACE;
            timing.zero_space     = irac_pkg::RST_ZERO_SPACE;
            timing.section_gap    = irac_pkg::RST_SECTION_GAP;
            sections_in_frame     = 0;
        endfunction

        // Indexes past the last timing register are ignored by the block.
        function void set_timing(logic [irac_pkg::CFG_IDX_W-1:0] idx,
                                 logic [irac_pkg::DUR_W-1:0] value);
            case (idx)
                irac_pkg::REG_HEADER_MARK:   timing.header_mark   = value;
                irac_pkg::REG_HEADER_SPACE:  timing.header_space  = value;
                irac_pkg::REG_SECTION_MARK:  timing.section_mark  = value;
                irac_pkg::REG_SECTION_SPACE: timing.section_space = value;
                irac_pkg::REG_BIT_MARK:      timing.bit_mark      = value;
                irac_pkg::REG_ONE_SPACE:     timing.one_space     = value;
                irac_pkg::REG_ZERO_SPACE:    timing.zero_space    = value;
                irac_pkg::REG_SECTION_GAP:   timing.section_gap   = value;
                default:                     ;
            endcase
        endfunction

        function void push_symbol(logic [irac_pkg::DUR_W-1:0] mark,
                                  logic [irac_pkg::DUR_W-1:0] space,
                                  logic eor, logic eof, logic err);
            irac_pkg::out_t sym;
            sym.mark_us      = mark;
            sym.space_us     = space;
            sym.end_of_run   = eor;
            sym.end_of_frame = eof;
            sym.error_code   = err;
            expected_symbols.push_back(sym);
        endfunction

        // Expands one accepted section into the symbols it must produce.
        function void note_section(irac_pkg::in_t item);
            // A section over the per-frame limit becomes a single error symbol.
            if (sections_in_frame >= max_sections)
            begin
                push_symbol('0, '0, 1'b1, item.last_section, 1'b1);
                if (item.last_section)
                    sections_in_frame = 0;
                return;
            end
            if (sections_in_frame == 0)
                push_symbol(timing.header_mark, timing.header_space, 1'b0, 1'b0, 1'b0);
            push_symbol(timing.section_mark, timing.section_space, 1'b0, 1'b0, 1'b0);
            for (int k = 0; k < irac_pkg::DATA_BITS; k++)
                push_symbol(timing.bit_mark,
                            item.section_bits[k] ? timing.one_space : timing.zero_space,
                            1'b0, 1'b0, 1'b0);
            // The foot closes either the frame or just this section.
            if (item.last_section)
            begin
                push_symbol(timing.bit_mark, last_foot_space, 1'b1, 1'b1, 1'b0);
                sections_in_frame = 0;
            end
            else
            begin
                push_symbol(timing.bit_mark, timing.section_gap, 1'b1, 1'b0, 1'b0);
                sections_in_frame++;
            end
        endfunction

        function void compare_field(string name, logic [irac_pkg::DUR_W-1:0] want,
                                    logic [irac_pkg::DUR_W-1:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_symbol(irac_pkg::out_t got);
            irac_pkg::out_t want;
            if (expected_symbols.size() == 0)
            begin
                $error("symbol with nothing expected: mark_us %0d space_us %0d",
                       got.mark_us, got.space_us);
                mismatches++;
                return;
            end
            want = expected_symbols.pop_front();
            compare_field("mark_us", want.mark_us, got.mark_us);
            compare_field("space_us", want.space_us, got.space_us);
            compare_field("end_of_run", irac_pkg::DUR_W'(want.end_of_run),
                          irac_pkg::DUR_W'(got.end_of_run));
            compare_field("end_of_frame", irac_pkg::DUR_W'(want.end_of_frame),
                          irac_pkg::DUR_W'(got.end_of_frame));
            compare_field("error_code", irac_pkg::DUR_W'(want.error_code),
                          irac_pkg::DUR_W'(got.error_code));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    irac_pkg::in_t                  in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    irac_pkg::out_t                 out_item;
    logic                           cfg_we = 1'b0;
    logic [irac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [irac_pkg::DUR_W-1:0]     cfg_data = '0;

    bit                             calm = 1'b0;
    int unsigned                    cycles = 0;
    symbol_scoreboard_t             book;

    ir_ac_frame_symbol_encoder_core #(
        .MAX_SECTIONS(MAX_SECTIONS),
        .FINAL_GAP_US(FINAL_GAP_US)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver holds off at random except during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 25);
    end

    // Every symbol taken from the block is checked in order.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            book.check_symbol(out_item);
    end

    task automatic write_reg(input logic [irac_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irac_pkg::DUR_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        book.set_timing(idx, value);
    endtask

    task automatic load_timings(input timing_mode_t mode);
        logic [irac_pkg::DUR_W-1:0] value;
        for (int r = 0; r <= irac_pkg::REG_SECTION_GAP; r++)
        begin
            case (mode)
                TIMING_ZERO: value = '0;
                TIMING_FULL: value = '1;
                default:     value = irac_pkg::DUR_W'($urandom_range(0, 65535));
            endcase
            write_reg(irac_pkg::CFG_IDX_W'(r), value);
        end
        // A write past the last register must leave every timing alone.
        write_reg(irac_pkg::CFG_IDX_W'(irac_pkg::REG_SECTION_GAP + $urandom_range(1, 8)),
                  irac_pkg::DUR_W'($urandom_range(0, 65535)));
    endtask

    // Offers one section and returns once the block has taken it.
    task automatic send_section(input logic [irac_pkg::DATA_BITS-1:0] bits,
                                input logic last);
        irac_pkg::in_t item;
        item.section_bits = bits;
        item.last_section = last;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_section(item);
    endtask

    // Lets every expected symbol come out, then waits out any trailing work.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.expected_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [irac_pkg::DATA_BITS-1:0] random_bits();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return irac_pkg::DATA_BITS'({$urandom, $urandom});
    endfunction

    // Mostly proper frames; the rest overlong frames or random frame flags.
    task automatic send_frames(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned kind;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                len = $urandom_range(1, MAX_SECTIONS);
            else
                len = $urandom_range(MAX_SECTIONS + 1, MAX_SECTIONS + 3);
            for (int s = 0; s < len && sent < count; s++)
            begin
                if (kind == 9)
                    send_section(random_bits(), 1'($urandom_range(0, 1)));
                else
                    send_section(random_bits(), s == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        book = new(MAX_SECTIONS, FINAL_GAP_US);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the default timings.
        send_section('0, 1'b1);
        send_section('1, 1'b0);
        send_section({7{8'hAA}}, 1'b0);
        send_section({7{8'h55}}, 1'b0);
        send_section(56'h0123456789ABCD, 1'b0);
        send_section('1, 1'b1);
        send_section(56'h80000000000001, 1'b1);
        send_section(56'h00000000000001, 1'b0);
        send_section(56'h80000000000000, 1'b0);
        send_section(random_bits(), 1'b1);
        send_section(random_bits(), 1'b0);
        drain();

        // Zero and full-scale timings.
        load_timings(TIMING_ZERO);
        send_section(56'h0F0F0F0F0F0F0F, 1'b1);
        send_frames(40);
        drain();
        load_timings(TIMING_FULL);
        send_section(56'hF0F0F0F0F0F0F0, 1'b1);
        send_frames(40);
        drain();

        // Random timings, the first stretch with no idling on either side.
        load_timings(TIMING_RANDOM);
        calm = 1'b1;
        send_frames(40);
        calm = 1'b0;
        send_frames(40);
        drain();
        load_timings(TIMING_RANDOM);
        send_frames(110);
        drain();

        if (book.expected_symbols.size() != 0)
        begin
            $error("%0d expected symbols never arrived", book.expected_symbols.size());
            book.mismatches++;
        end
        if (book.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
